>>> src/bdat_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bounded-degree adjacency table.
// Used by bdat_ctrl, bdat_dp and the top level; depends on nothing else.
package bdat_pkg;

  localparam int NODE_W       = 8;   // node index field
  localparam int CMD_W        = 2;
  localparam int DEG_W        = 4;   // reported degree field
  localparam int LIM_W        = 5;   // compare width for degree limits (up to 16)
  localparam int NODE_COUNT_W = 9;
  localparam int DEG_LIMIT_W  = 4;
  localparam int APB_DW       = 32;
  localparam int APB_AW       = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic {
    REG_NODE_COUNT   = 1'b0,
    REG_DEGREE_LIMIT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_UPDATE,
    S_WR_B,
    S_CLEAR
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture the incoming word
    logic rd_b;         // read row of node b (else node a)
    logic latch_a;      // row a is on the read data, keep it
    logic update;       // row b is on the read data, compute and write row a
    logic write_b;      // write the updated row b
    logic sweep;        // write one zero row of the clearing sweep
    logic zero_result;  // result of a clear command: all fields zero
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_clear;
    logic sweep_last;
  } dp_stat_t;

endpackage

>>> src/bdat_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine for the adjacency table.
// Depends on bdat_pkg; drives the datapath bdat_dp through dp_cmd_t.
module bdat_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output bdat_pkg::dp_cmd_t  cmd,
  input  bdat_pkg::dp_stat_t stat
);
  import bdat_pkg::*;

  state_t state_r, state_nxt;
  logic   clear_cmd_r, clear_cmd_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Reset enters the clearing sweep so that every row starts with a zero count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clear_cmd_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clear_cmd_r <= clear_cmd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clear_cmd_nxt = clear_cmd_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD_A;
        end
      end
      S_RD_A: begin
        if (stat.is_clear) begin
          cmd.zero_result = 1'b1;
          clear_cmd_nxt   = 1'b1;
          state_nxt       = S_CLEAR;
        end else begin
          state_nxt = S_RD_B;
        end
      end
      S_RD_B: begin
        cmd.rd_b    = 1'b1;
        cmd.latch_a = 1'b1;
        state_nxt   = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_WR_B;
      end
      S_WR_B: begin
        cmd.write_b   = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          out_valid_nxt = clear_cmd_r;
          clear_cmd_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_strobe_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result strobe while a command is still in progress");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_WR_B || $past(state_r) == S_CLEAR)
    else $error("result strobe not preceded by a write-back or a clear");

  a_sweep_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR && !stat.sweep_last |=> state_r == S_CLEAR)
    else $error("clearing sweep left before the last row");
`endif

endmodule

>>> src/bdat_dp.sv
`timescale 1ns / 1ps
// Datapath of the adjacency table: row memory, sweep counter, row update logic
// and result registers. Depends on bdat_pkg; controlled by bdat_ctrl.
module bdat_dp #(
  parameter int MAX_NODES  = 256,
  parameter int MAX_DEGREE = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [bdat_pkg::CMD_W-1:0]            in_command,
  input  logic [bdat_pkg::NODE_W-1:0]           in_node_a,
  input  logic [bdat_pkg::NODE_W-1:0]           in_node_b,
  input  logic [bdat_pkg::NODE_COUNT_W-1:0]     node_count,
  input  logic [bdat_pkg::DEG_LIMIT_W-1:0]      degree_limit,
  input  bdat_pkg::dp_cmd_t                     cmd,
  output bdat_pkg::dp_stat_t                    stat,
  output logic                                  out_edge_present,
  output logic [bdat_pkg::DEG_W-1:0]            out_degree_a,
  output logic [bdat_pkg::DEG_W-1:0]            out_degree_b,
  output logic [1:0]                            out_status
);
  import bdat_pkg::*;

  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_DEGREE + 1);
  localparam int SW = MAX_DEGREE * NODE_W;
  localparam int RW = SW + CW;

  typedef logic [MAX_DEGREE-1:0][NODE_W-1:0] slots_t;

  // Command word
  cmd_t              cmd_r;
  logic [NODE_W-1:0] a_r, b_r;
  logic              aok, bok, is_loop;
  logic [AW+NODE_W-1:0] ext_a, ext_b;
  logic [AW-1:0]     addr_a, addr_b;

  // Memory and sweep
  logic [RW-1:0]     mem [MAX_NODES];
  logic [RW-1:0]     rdata_r;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [RW-1:0]     wr_data;
  logic [AW-1:0]     sweep_r;
  logic              sweep_last;

  // Rows
  logic [RW-1:0]     row_a_r;
  slots_t            slots_a, slots_b, new_sa, new_sb;
  logic [CW-1:0]     cnt_a, cnt_b, new_ca, new_cb;
  logic [LIM_W-1:0]  lim;

  // Matching
  logic [MAX_DEGREE-1:0] ma, ma2, mb, mp;
  logic [CW-1:0]     d1, d2, db;
  logic [CW-1:0]     tail_a1, tail_a2, tail_b;
  logic [NODE_W-1:0] val_a1, val_a2, val_b, val_loop;

  // Update results
  status_t           status_nxt;
  logic              wr_ok;
  logic [CW+DEG_W-1:0] ext_ca, ext_cb;

  logic [RW-1:0]     new_row_b_r;
  logic              we_b_r;
  logic              present_r;
  logic [DEG_W-1:0]  deg_a_r, deg_b_r;
  status_t           status_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= cmd_t'(in_command);
      a_r   <= in_node_a;
      b_r   <= in_node_b;
    end
  end

  assign aok     = ({1'b0, a_r} < node_count) && (32'(a_r) < MAX_NODES);
  assign bok     = ({1'b0, b_r} < node_count) && (32'(b_r) < MAX_NODES);
  assign is_loop = (a_r == b_r);
  assign ext_a   = {{AW{1'b0}}, a_r};
  assign ext_b   = {{AW{1'b0}}, b_r};
  assign addr_a  = ext_a[AW-1:0];
  assign addr_b  = ext_b[AW-1:0];

  // Clearing sweep over all rows, wrapping back to row zero at the end.
  assign sweep_last = (sweep_r == AW'(MAX_NODES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.sweep) begin
      sweep_r <= sweep_last ? '0 : sweep_r + AW'(1);
    end
  end

  assign stat.is_clear   = (cmd_r == CMD_CLEAR);
  assign stat.sweep_last = sweep_last;

  // Row memory: one read, one write per cycle, registered read data.
  assign rd_addr = cmd.rd_b ? addr_b : addr_a;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_a;
    wr_data = {new_ca, new_sa};
    priority if (cmd.sweep) begin
      wr_en   = 1'b1;
      wr_addr = sweep_r;
      wr_data = '0;
    end else if (cmd.update) begin
      wr_en = wr_ok;
    end else if (cmd.write_b) begin
      wr_en   = we_b_r;
      wr_addr = addr_b;
      wr_data = new_row_b_r;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_a) begin
      row_a_r <= rdata_r;
    end
  end

  assign slots_a = row_a_r[SW-1:0];
  assign cnt_a   = row_a_r[RW-1:SW];
  assign slots_b = rdata_r[SW-1:0];
  assign cnt_b   = rdata_r[RW-1:SW];

  assign lim = ({1'b0, degree_limit} < LIM_W'(MAX_DEGREE)) ?
               {1'b0, degree_limit} : LIM_W'(MAX_DEGREE);

  assign tail_a1 = cnt_a - CW'(1);
  assign tail_a2 = cnt_a - CW'(2);
  assign tail_b  = cnt_b - CW'(1);

  // Slot matches within each list's filled part, first and second hit.
  always_comb begin
    ma     = '0;
    mb     = '0;
    ma2    = '0;
    d1     = '0;
    d2     = '0;
    db     = '0;
    val_a1 = '0;
    val_a2 = '0;
    val_b  = '0;
    for (int d = 0; d < MAX_DEGREE; d++) begin
      ma[d] = (CW'(d) < cnt_a) && (slots_a[d] == b_r);
      mb[d] = (CW'(d) < cnt_b) && (slots_b[d] == a_r);
      if (CW'(d) == tail_a1) val_a1 = slots_a[d];
      if (CW'(d) == tail_a2) val_a2 = slots_a[d];
      if (CW'(d) == tail_b)  val_b  = slots_b[d];
    end
    for (int d = MAX_DEGREE - 1; d >= 0; d--) begin
      if (ma[d]) d1 = CW'(d);
      if (mb[d]) db = CW'(d);
    end
    for (int d = 0; d < MAX_DEGREE; d++) begin
      ma2[d] = ma[d] && (CW'(d) != d1);
    end
    for (int d = MAX_DEGREE - 1; d >= 0; d--) begin
      if (ma2[d]) d2 = CW'(d);
    end
  end

  // Removing a loop: the second copy takes the entry just below the tail, then
  // the first copy takes the tail as it stands after that move.
  assign val_loop = (tail_a1 == d2) ? val_a2 : val_a1;

  always_comb begin
    status_nxt = ST_OK;
    wr_ok      = 1'b0;
    new_sa     = slots_a;
    new_ca     = cnt_a;
    new_sb     = slots_b;
    new_cb     = cnt_b;
    if (!aok || !bok) begin
      status_nxt = ST_RANGE;
    end else begin
      unique case (cmd_r)
        CMD_ADD: begin
          if (is_loop) begin
            if ((LIM_W + 1)'(cnt_a) + (LIM_W + 1)'(2) > (LIM_W + 1)'(lim)) begin
              status_nxt = ST_FULL;
            end else begin
              for (int d = 0; d < MAX_DEGREE; d++) begin
                if (CW'(d) == cnt_a || CW'(d) == cnt_a + CW'(1)) new_sa[d] = a_r;
              end
              new_ca = cnt_a + CW'(2);
              wr_ok  = 1'b1;
            end
          end else if (LIM_W'(cnt_a) >= lim || LIM_W'(cnt_b) >= lim) begin
            status_nxt = ST_FULL;
          end else begin
            for (int d = 0; d < MAX_DEGREE; d++) begin
              if (CW'(d) == cnt_a) new_sa[d] = b_r;
              if (CW'(d) == cnt_b) new_sb[d] = a_r;
            end
            new_ca = cnt_a + CW'(1);
            new_cb = cnt_b + CW'(1);
            wr_ok  = 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (is_loop) begin
            if (!((|ma) && (|ma2))) begin
              status_nxt = ST_MISSING;
            end else begin
              for (int d = 0; d < MAX_DEGREE; d++) begin
                if (CW'(d) == d1)      new_sa[d] = val_loop;
                else if (CW'(d) == d2) new_sa[d] = val_a2;
              end
              new_ca = cnt_a - CW'(2);
              wr_ok  = 1'b1;
            end
          end else if (!((|ma) && (|mb))) begin
            status_nxt = ST_MISSING;
          end else begin
            for (int d = 0; d < MAX_DEGREE; d++) begin
              if (CW'(d) == d1) new_sa[d] = val_a1;
              if (CW'(d) == db) new_sb[d] = val_b;
            end
            new_ca = tail_a1;
            new_cb = tail_b;
            wr_ok  = 1'b1;
          end
        end
        CMD_QUERY: begin
          wr_ok = 1'b0;
        end
        CMD_CLEAR: begin
          wr_ok = 1'b0;
        end
      endcase
    end
    // For a loop both rows are the same row.
    if (is_loop) begin
      new_sb = new_sa;
      new_cb = new_ca;
    end
  end

  // Edge test on node a's list as it stands after the command.
  always_comb begin
    mp = '0;
    for (int d = 0; d < MAX_DEGREE; d++) begin
      mp[d] = (CW'(d) < new_ca) && (new_sa[d] == b_r);
    end
  end

  assign ext_ca = {{DEG_W{1'b0}}, new_ca};
  assign ext_cb = {{DEG_W{1'b0}}, new_cb};

  always_ff @(posedge clk) begin
    if (cmd.zero_result) begin
      present_r <= 1'b0;
      deg_a_r   <= '0;
      deg_b_r   <= '0;
      status_r  <= ST_OK;
    end else if (cmd.update) begin
      present_r   <= aok && bok && (|mp);
      deg_a_r     <= aok ? ext_ca[DEG_W-1:0] : '0;
      deg_b_r     <= bok ? ext_cb[DEG_W-1:0] : '0;
      status_r    <= status_nxt;
      new_row_b_r <= {new_cb, new_sb};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      we_b_r <= 1'b0;
    end else if (cmd.update) begin
      we_b_r <= wr_ok;
    end
  end

  assign out_edge_present = present_r;
  assign out_degree_a     = deg_a_r;
  assign out_degree_b     = deg_b_r;
  assign out_status       = status_r;

endmodule

>>> src/bounded_degree_adjacency_table.sv
`timescale 1ns / 1ps
// Top level of the bounded-degree adjacency table: configuration registers,
// controller bdat_ctrl and datapath bdat_dp. Depends on bdat_pkg.
//
// Usage. A command word (in_command, in_node_a, in_node_b) is taken at a
// rising edge where start is high and busy is low. Commands are add edge,
// remove edge, query edge and clear all. Exactly one result word follows:
// out_edge_present, out_degree_a, out_degree_b and out_status, shown for a
// single cycle with out_valid high. The receiver cannot stall, so it must
// take the word in that cycle.
// Sequence. Add, remove and query step through the busy states read row a,
// read row b, update and write row a, and write row b, after the accepting
// edge. The result is registered at the end of write row b; busy is already
// low while it shows, so a new command can be accepted at the edge that ends
// the result cycle. A command is thus taken only after the last one has
// written row b, since the row memory has a single read and write port.
// A clear command writes one zero row per cycle until all MAX_NODES rows
// are zero, then gives its result (status ok, all other fields zero).
// Reset. After rst_n is released the block runs the same sweep, staying busy
// until the last row is written, with no result for it. Configuration goes
// through the APB port at any time, but should only be written while idle.
module bounded_degree_adjacency_table #(
  parameter int MAX_NODES  = 256,
  parameter int MAX_DEGREE = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Command channel
  input  logic                             start,
  output logic                             busy,
  input  logic [bdat_pkg::CMD_W-1:0]       in_command,
  input  logic [bdat_pkg::NODE_W-1:0]      in_node_a,
  input  logic [bdat_pkg::NODE_W-1:0]      in_node_b,
  // Result channel
  output logic                             out_valid,
  output logic                             out_edge_present,
  output logic [bdat_pkg::DEG_W-1:0]       out_degree_a,
  output logic [bdat_pkg::DEG_W-1:0]       out_degree_b,
  output logic [1:0]                       out_status,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bdat_pkg::APB_AW-1:0]      paddr,
  input  logic [bdat_pkg::APB_DW-1:0]      pwdata,
  output logic [bdat_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);
  import bdat_pkg::*;

  logic [NODE_COUNT_W-1:0] node_count_r;
  logic [DEG_LIMIT_W-1:0]  degree_limit_r;
  reg_idx_t                reg_idx;
  dp_cmd_t                 dp_cmd;
  dp_stat_t                dp_stat;

  // Registers sit at byte addresses 0 and 4, so bit 2 selects one.
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r   <= NODE_COUNT_W'(256);
      degree_limit_r <= DEG_LIMIT_W'(8);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_NODE_COUNT:   node_count_r   <= pwdata[NODE_COUNT_W-1:0];
        REG_DEGREE_LIMIT: degree_limit_r <= pwdata[DEG_LIMIT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NODE_COUNT:   prdata = {{(APB_DW - NODE_COUNT_W){1'b0}}, node_count_r};
      REG_DEGREE_LIMIT: prdata = {{(APB_DW - DEG_LIMIT_W){1'b0}}, degree_limit_r};
    endcase
  end

  bdat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  bdat_dp #(
    .MAX_NODES  (MAX_NODES),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_command),
    .in_node_a        (in_node_a),
    .in_node_b        (in_node_b),
    .node_count       (node_count_r),
    .degree_limit     (degree_limit_r),
    .cmd              (dp_cmd),
    .stat             (dp_stat),
    .out_edge_present (out_edge_present),
    .out_degree_a     (out_degree_a),
    .out_degree_b     (out_degree_b),
    .out_status       (out_status)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bounded_degree_adjacency_table: a shadow copy of the
// adjacency rows and degree counts predicts every result word. Depends on bdat_pkg.
module tb;
  import bdat_pkg::*;

  localparam int TB_MAX_NODES  = 256;
  localparam int TB_MAX_DEGREE = 8;
  // The cycle limit must cover the slowest correct run (gaps, clears and the reset sweep).
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 100;

  // One result word as the block should show it.
  typedef struct packed {
    logic             present;
    logic [DEG_W-1:0] deg_a;
    logic [DEG_W-1:0] deg_b;
    status_t          status;
  } answer_t;

  // Shadow of the adjacency table. It is updated when a command word is
  // accepted. The answers that the block owes are kept in order.
  class adjacency_shadow;
    bit [NODE_W-1:0] row [TB_MAX_NODES][TB_MAX_DEGREE];
    int unsigned     degree [TB_MAX_NODES];
    int unsigned     node_count_r;
    int unsigned     degree_limit_r;
    answer_t         answers_due [$];
    int              errors;

    function new();
      foreach (degree[i]) degree[i] = 0;
      node_count_r   = 256;
      degree_limit_r = 8;
      errors         = 0;
    endfunction

    function int unsigned nodes_in_use();
      return (node_count_r < TB_MAX_NODES) ? node_count_r : TB_MAX_NODES;
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    function void set_register(reg_idx_t idx, logic [APB_DW-1:0] value);
      if (idx == REG_NODE_COUNT) node_count_r = value[NODE_COUNT_W-1:0];
      else degree_limit_r = value[DEG_LIMIT_W-1:0];
    endfunction

    function void report_mismatch(string field, logic [APB_DW-1:0] want,
                                  logic [APB_DW-1:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    // First slot at or after first that holds target, or -1.
    function int find_slot(int unsigned n, logic [NODE_W-1:0] target, int first);
      int cnt;
      cnt = (degree[n] > TB_MAX_DEGREE) ? TB_MAX_DEGREE : degree[n];
      for (int d = first; d < cnt; d++)
        if (row[n][d] == target) return d;
      return -1;
    endfunction

    function void append(int unsigned n, logic [NODE_W-1:0] v);
      if (degree[n] < TB_MAX_DEGREE) begin
        row[n][degree[n]] = v;
        degree[n]++;
      end
    endfunction

    // The tail entry fills the vacated slot.
    function void drop(int unsigned n, int d);
      int unsigned tail;
      tail = degree[n] - 1;
      row[n][d] = row[n][tail];
      degree[n] = tail;
    endfunction

    function void take_command(cmd_t c, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
      answer_t     ans;
      bit          a_ok, b_ok;
      int unsigned lim, n;
      int          s1, s2;
      a_ok = a < nodes_in_use();
      b_ok = b < nodes_in_use();
      lim  = (degree_limit_r < TB_MAX_DEGREE) ? degree_limit_r : TB_MAX_DEGREE;
      ans  = '0;
      ans.status = ST_OK;
      if (c == CMD_CLEAR) begin
        foreach (degree[i]) degree[i] = 0;
      end else if (!a_ok || !b_ok) begin
        ans.status = ST_RANGE;
      end else if (c == CMD_ADD) begin
        // A loop needs two free ends at its node, a plain edge one at each end.
        if (a == b) begin
          if (degree[a] + 2 > lim) ans.status = ST_FULL;
          else begin
            append(a, a);
            append(a, a);
          end
        end else if (degree[a] >= lim || degree[b] >= lim) begin
          ans.status = ST_FULL;
        end else begin
          append(a, b);
          append(b, a);
        end
      end else if (c == CMD_REMOVE) begin
        if (a == b) begin
          s1 = find_slot(a, a, 0);
          s2 = (s1 >= 0) ? find_slot(a, a, s1 + 1) : -1;
          if (s2 < 0) ans.status = ST_MISSING;
          else begin
            n = degree[a];
            row[a][s2] = row[a][n-2];
            row[a][s1] = row[a][n-1];
            degree[a]  = n - 2;
          end
        end else begin
          s1 = find_slot(a, b, 0);
          s2 = find_slot(b, a, 0);
          if (s1 < 0 || s2 < 0) ans.status = ST_MISSING;
          else begin
            drop(a, s1);
            drop(b, s2);
          end
        end
      end
      if (c != CMD_CLEAR) begin
        if (a_ok) begin
          ans.deg_a = DEG_W'(degree[a]);
          if (b_ok) ans.present = find_slot(a, b, 0) >= 0;
        end
        if (b_ok) ans.deg_b = DEG_W'(degree[b]);
      end
      answers_due.push_back(ans);
    endfunction

    function void check_answer(logic present, logic [DEG_W-1:0] deg_a,
                               logic [DEG_W-1:0] deg_b, logic [1:0] status);
      answer_t want;
      if (answers_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result word with no command waiting for it", $time);
        return;
      end
      want = answers_due.pop_front();
      if (present !== want.present) report_mismatch("edge_present", want.present, present);
      if (deg_a !== want.deg_a) report_mismatch("degree_a", want.deg_a, deg_a);
      if (deg_b !== want.deg_b) report_mismatch("degree_b", want.deg_b, deg_b);
      if (status !== want.status) report_mismatch("status", want.status, status);
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [CMD_W-1:0]        in_command;
  logic [NODE_W-1:0]       in_node_a;
  logic [NODE_W-1:0]       in_node_b;
  logic                    out_valid;
  logic                    out_edge_present;
  logic [DEG_W-1:0]        out_degree_a;
  logic [DEG_W-1:0]        out_degree_b;
  logic [1:0]              out_status;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [APB_AW-1:0]       paddr;
  logic [APB_DW-1:0]       pwdata;
  logic [APB_DW-1:0]       prdata;
  logic                    pready;

  adjacency_shadow adjacency = new();
  bit              idle_en = 1'b1;
  int unsigned     cycle_count = 0;

  bounded_degree_adjacency_table #(
    .MAX_NODES  (TB_MAX_NODES),
    .MAX_DEGREE (TB_MAX_DEGREE)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_node_a        (in_node_a),
    .in_node_b        (in_node_b),
    .out_valid        (out_valid),
    .out_edge_present (out_edge_present),
    .out_degree_a     (out_degree_a),
    .out_degree_b     (out_degree_b),
    .out_status       (out_status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Result words are valid for exactly one cycle and cannot be held off, so
  // every edge with out_valid high delivers one. The values read right after
  // the edge are the ones the edge sampled.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      adjacency.check_answer(out_edge_present, out_degree_a, out_degree_b, out_status);
  end

  // Offers one command word and returns at the edge that accepts it. Start
  // stays high unless an idle gap is taken, so a caller that issues the next
  // word at once keeps the block fed back to back. The random gap length varies
  // the phase of the next start against the block's busy cycles.
  task automatic issue(cmd_t c, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
    int gap;
    start      <= 1'b1;
    in_command <= c;
    in_node_a  <= a;
    in_node_b  <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    adjacency.take_command(c, a, b);
    if (idle_en && $urandom_range(0, 99) < 14) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Register writes happen only with the block idle: no command offered, no
  // answer outstanding and busy low (this also covers the sweep after reset
  // and the sweep of a clear). Each write is read back.
  task automatic write_register(reg_idx_t idx, logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] mask;
    mask = (idx == REG_NODE_COUNT) ? APB_DW'((1 << NODE_COUNT_W) - 1)
                                   : APB_DW'((1 << DEG_LIMIT_W) - 1);
    start <= 1'b0;
    while (adjacency.pending() != 0 || busy) @(posedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    adjacency.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if ((prdata & mask) !== (value & mask))
      adjacency.report_mismatch("register readback", value & mask, prdata & mask);
    psel    <= 1'b0;
    penable <= 1'b0;
    // Leave the bus idle before the next transfer.
    @(posedge clk);
  endtask

  // Most node picks come from a small group of low nodes so that edges pile
  // up and degrees fill. The rest hit the top valid node, the first invalid
  // one, or anything in the field's range.
  function automatic logic [NODE_W-1:0] pick_node();
    int unsigned span, roll;
    span = adjacency.nodes_in_use();
    roll = $urandom_range(0, 99);
    if (span == 0 || roll < 12) return NODE_W'($urandom_range(0, 255));
    if (roll < 18) return NODE_W'(span - 1);
    if (roll < 22 && span < TB_MAX_NODES) return NODE_W'(span);
    return NODE_W'($urandom_range(0, ((span < 12) ? span : 12) - 1));
  endfunction

  // Removes and queries usually name an edge that exists, taken from the
  // shadow's neighbor row. Clears are rare since each one sweeps every row.
  task automatic random_command();
    cmd_t              c;
    logic [NODE_W-1:0] a, b;
    int unsigned       roll, d;
    roll = $urandom_range(0, 99);
    a    = pick_node();
    b    = pick_node();
    if (roll < 2) c = CMD_CLEAR;
    else if (roll < 45) c = CMD_ADD;
    else if (roll < 75) c = CMD_REMOVE;
    else c = CMD_QUERY;
    if ($urandom_range(0, 9) == 0) begin
      b = a;
    end else if (c != CMD_ADD && $urandom_range(0, 9) < 7) begin
      d = adjacency.degree[a];
      if (d > TB_MAX_DEGREE) d = TB_MAX_DEGREE;
      if (d > 0) b = adjacency.row[a][$urandom_range(0, d - 1)];
    end
    issue(c, a, b);
  endtask

  // Random phases: node count and degree limit per phase, including values
  // past the node store and past the degree store. Phase order matters: the
  // limit drops below counts built up in earlier phases without a clear.
  int unsigned plan_nodes [7] = '{256, 16, 511, 2, 16, 1, 256};
  int unsigned plan_limit [7] = '{8, 3, 15, 2, 1, 1, 8};
  int unsigned plan_items [7] = '{100, 100, 100, 70, 70, 60, 100};

  initial begin
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_command <= CMD_ADD;
    in_node_a  <= '0;
    in_node_b  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // Let the reset release reach the block before looking at busy; the
    // register task then waits out the clearing sweep.
    repeat (2) @(posedge clk);

    write_register(REG_NODE_COUNT, 256);
    write_register(REG_DEGREE_LIMIT, 8);

    // Extreme node indices, a duplicate edge and its removal one copy at a
    // time, then a missing edge.
    issue(CMD_ADD, 0, 255);
    issue(CMD_ADD, 0, 255);
    issue(CMD_QUERY, 255, 0);
    issue(CMD_REMOVE, 0, 255);
    issue(CMD_QUERY, 0, 255);
    issue(CMD_REMOVE, 0, 255);
    issue(CMD_REMOVE, 0, 255);
    // Loops fill node 7 to the limit; both a loop and a plain edge are then
    // refused as full. Loop removal needs both copies.
    repeat (4) issue(CMD_ADD, 7, 7);
    issue(CMD_ADD, 7, 7);
    issue(CMD_ADD, 7, 9);
    issue(CMD_REMOVE, 9, 9);
    issue(CMD_REMOVE, 7, 7);
    issue(CMD_ADD, 7, 9);
    issue(CMD_QUERY, 7, 7);
    issue(CMD_CLEAR, 255, 255);
    issue(CMD_QUERY, 7, 9);

    // With no nodes in use every command but a clear is out of range.
    write_register(REG_NODE_COUNT, 0);
    issue(CMD_ADD, 0, 0);
    issue(CMD_QUERY, 3, 4);
    issue(CMD_REMOVE, 0, 255);

    // A zero degree limit refuses every add.
    write_register(REG_NODE_COUNT, 16);
    write_register(REG_DEGREE_LIMIT, 0);
    issue(CMD_ADD, 1, 2);
    issue(CMD_ADD, 3, 3);
    issue(CMD_ADD, 15, 16);
    issue(CMD_QUERY, 16, 15);

    foreach (plan_nodes[p]) begin
      write_register(REG_NODE_COUNT, plan_nodes[p]);
      write_register(REG_DEGREE_LIMIT, plan_limit[p]);
      // One phase runs without any idle gaps on the command side.
      idle_en = (p != 2);
      repeat (plan_items[p]) random_command();
    end

    start <= 1'b0;
    while (adjacency.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (adjacency.errors == 0 && adjacency.pending() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
